[rtl/ptc_pkg.sv]
package ptc_pkg;

    localparam int RAW_W     = 24;
    localparam int COEF_W    = 16;
    localparam int TEMP_W    = 19;
    localparam int PTENTH_W  = 32;
    localparam int PMBAR_W   = 29;
    localparam int CFG_IDX_W = 3;

    // register stages from accepted reading to result strobe
    localparam int LATENCY = 15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESSURE_SENSITIVITY   = 3'd0,
        CFG_PRESSURE_OFFSET        = 3'd1,
        CFG_SENSITIVITY_TEMP_COEFF = 3'd2,
        CFG_OFFSET_TEMP_COEFF      = 3'd3,
        CFG_REFERENCE_TEMPERATURE  = 3'd4,
        CFG_TEMPERATURE_COEFF      = 3'd5
    } ptc_cfg_idx_t;

    // signed division by 2^k, rounding toward zero
    function automatic logic signed [71:0] sdiv_pow2(input logic signed [71:0] x,
                                                     input int unsigned k);
        logic signed [71:0] bias;
        bias = x[71] ? ((72'sd1 <<< k) - 72'sd1) : 72'sd0;
        return (x + bias) >>> k;
    endfunction

endpackage

[rtl/pressure_temperature_compensation.sv]
// Second-order pressure/temperature compensation for a 24-bit sensor, in exact
// integer arithmetic. A transaction on start/busy carries one raw pressure and
// one raw temperature reading; busy never rises, so a reading pair may be
// issued on every clock. Each pair produces exactly one result, strobed on
// result_valid for a single cycle; the receiver cannot hold results off and
// must capture them on that cycle. Sustained rate is one pair per clock in a
// 15-stage pipeline (coefficient products, squares, second-order corrections,
// the 24 x 42 bit pressure product in two partial products, and the division
// by ten by a reciprocal multiply). The six calibration words are written
// through the cfg port (index 0..5, other indexes ignored; cfg_ready is
// always high) and must only be changed while no reading is in flight.
// Outputs: temperature in 0.01 degC, pressure in 0.1 mbar saturated to 32
// bits, and pressure in mbar.
module pressure_temperature_compensation
    import ptc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       start,
    output logic                       busy,
    input  logic [RAW_W-1:0]           raw_pressure,
    input  logic [RAW_W-1:0]           raw_temperature,

    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [COEF_W-1:0]          cfg_data,

    output logic                       result_valid,
    output logic signed [TEMP_W-1:0]   temperature_centideg,
    output logic signed [PTENTH_W-1:0] pressure_tenth_mbar,
    output logic signed [PMBAR_W-1:0]  pressure_mbar
);

    // TEMP ref 20 degC; very-low terms apply for TEMP < -1500 (degC*100)
    localparam logic signed [TEMP_W-1:0] TEMP_REF = 19'sd2000;
    localparam logic signed [TEMP_W-1:0] VLOW_OFS = 19'sd3500;
    localparam logic signed [32:0]       P_MAX    = 33'sd2147483647;
    localparam logic signed [32:0]       P_MIN    = -33'sd2147483648;
    // floor(x * DIV10_MUL / 2^35) == x / 10 for every 32-bit unsigned x
    localparam logic [31:0]              DIV10_MUL = 32'hCCCC_CCCD;

    // ------------------------------------------------------------------
    // Calibration registers
    // ------------------------------------------------------------------
    logic [COEF_W-1:0] psens_reg;   // pressure sensitivity
    logic [COEF_W-1:0] poff_reg;    // pressure offset
    logic [COEF_W-1:0] tcs_reg;     // temp coefficient of sensitivity
    logic [COEF_W-1:0] tco_reg;     // temp coefficient of offset
    logic [COEF_W-1:0] tref_reg;    // reference temperature / 256
    logic [COEF_W-1:0] tsens_reg;   // temp coefficient of temperature

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            psens_reg <= '0;
            poff_reg  <= '0;
            tcs_reg   <= '0;
            tco_reg   <= '0;
            tref_reg  <= '0;
            tsens_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (ptc_cfg_idx_t'(cfg_index))
                CFG_PRESSURE_SENSITIVITY:   psens_reg <= cfg_data;
                CFG_PRESSURE_OFFSET:        poff_reg  <= cfg_data;
                CFG_SENSITIVITY_TEMP_COEFF: tcs_reg   <= cfg_data;
                CFG_OFFSET_TEMP_COEFF:      tco_reg   <= cfg_data;
                CFG_REFERENCE_TEMPERATURE:  tref_reg  <= cfg_data;
                CFG_TEMPERATURE_COEFF:      tsens_reg <= cfg_data;
                default: ;                  // unknown index: write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Valid pipeline. Nothing downstream can stall, so every stage moves
    // on every clock.
    // ------------------------------------------------------------------
    logic                accept;
    logic [LATENCY-1:0]  valid_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[LATENCY-2:0], accept};
        end
    end

    assign result_valid = valid_reg[LATENCY-1];

    // ------------------------------------------------------------------
    // Stage 1: dT = D2 - C5 * 2^8
    // ------------------------------------------------------------------
    logic signed [24:0] s1_dt_next, s1_dt_reg;
    logic [RAW_W-1:0]   s1_d1_reg;

    assign s1_dt_next = $signed({1'b0, raw_temperature}) - $signed({1'b0, tref_reg, 8'b0});

    // ------------------------------------------------------------------
    // Stage 2: coefficient products and dT^2
    // ------------------------------------------------------------------
    logic signed [41:0] s2_tc_next, s2_tc_reg;     // dT * C6
    logic signed [41:0] s2_oc_next, s2_oc_reg;     // dT * C4
    logic signed [41:0] s2_sc_next, s2_sc_reg;     // dT * C3
    logic signed [49:0] s2_dtsq_full;
    logic [47:0]        s2_dtsq_next, s2_dtsq_reg;
    logic [RAW_W-1:0]   s2_d1_reg;

    assign s2_tc_next   = s1_dt_reg * $signed({1'b0, tsens_reg});
    assign s2_oc_next   = s1_dt_reg * $signed({1'b0, tco_reg});
    assign s2_sc_next   = s1_dt_reg * $signed({1'b0, tcs_reg});
    assign s2_dtsq_full = s1_dt_reg * s1_dt_reg;
    assign s2_dtsq_next = s2_dtsq_full[47:0];

    // ------------------------------------------------------------------
    // Stage 3: TEMP, OFF, SENS and the temperature correction Ti
    // ------------------------------------------------------------------
    logic signed [TEMP_W-1:0] s3_dtemp_next, s3_dtemp_reg;   // TEMP - 2000
    logic signed [TEMP_W-1:0] s3_temp_next, s3_temp_reg;
    logic signed [35:0]       s3_off_next, s3_off_reg;
    logic signed [35:0]       s3_sens_next, s3_sens_reg;
    logic                     s3_low_next, s3_low_reg;       // TEMP < 20 degC
    logic                     s3_vlow_next, s3_vlow_reg;     // TEMP < -15 degC
    logic [49:0]              s3_dtsq3;
    logic [16:0]              s3_ti_next, s3_ti_reg;
    logic [RAW_W-1:0]         s3_d1_reg;

    assign s3_dtemp_next = TEMP_W'(sdiv_pow2(72'(s2_tc_reg), 23));
    assign s3_temp_next  = s3_dtemp_next + TEMP_REF;
    assign s3_off_next   = $signed({4'b0, poff_reg, 16'b0}) + 36'(sdiv_pow2(72'(s2_oc_reg), 7));
    assign s3_sens_next  = $signed({5'b0, psens_reg, 15'b0}) + 36'(sdiv_pow2(72'(s2_sc_reg), 8));
    assign s3_low_next   = s3_dtemp_next[TEMP_W-1];
    assign s3_vlow_next  = s3_dtemp_next < -VLOW_OFS;
    // dT^2 is non-negative, so plain shifts truncate correctly
    assign s3_dtsq3      = {2'b0, s2_dtsq_reg} + {1'b0, s2_dtsq_reg, 1'b0};
    assign s3_ti_next    = s3_low_next ? s3_dtsq3[49:33] : {5'b0, s2_dtsq_reg[47:36]};

    // ------------------------------------------------------------------
    // Stage 4: output temperature, squares for the offset terms
    // ------------------------------------------------------------------
    logic signed [TEMP_W-1:0] s4_tcomp_next, s4_tcomp_reg;
    logic signed [TEMP_W-1:0] s4_lo;                         // TEMP + 1500
    logic signed [37:0]       s4_sq1_full, s4_sq2_full;
    logic [35:0]              s4_sq1_next, s4_sq1_reg;
    logic [35:0]              s4_sq2_next, s4_sq2_reg;
    logic signed [35:0]       s4_off_reg, s4_sens_reg;
    logic                     s4_low_reg, s4_vlow_reg;
    logic [RAW_W-1:0]         s4_d1_reg;

    assign s4_tcomp_next = s3_temp_reg - $signed({2'b0, s3_ti_reg});
    assign s4_lo         = s3_dtemp_reg + VLOW_OFS;
    assign s4_sq1_full   = s3_dtemp_reg * s3_dtemp_reg;
    assign s4_sq2_full   = s4_lo * s4_lo;
    assign s4_sq1_next   = s4_sq1_full[35:0];
    assign s4_sq2_next   = s4_sq2_full[35:0];

    // ------------------------------------------------------------------
    // Stage 5: second-order offset and sensitivity corrections
    // ------------------------------------------------------------------
    logic [37:0]              s5_sq1x3;
    logic [38:0]              s5_sq1x5;
    logic [38:0]              s5_sq2x7;
    logic [39:0]              s5_offi_next, s5_offi_reg;
    logic [39:0]              s5_sensi_next, s5_sensi_reg;
    logic signed [35:0]       s5_off_reg, s5_sens_reg;
    logic signed [TEMP_W-1:0] s5_tcomp_reg;
    logic [RAW_W-1:0]         s5_d1_reg;

    assign s5_sq1x3 = {2'b0, s4_sq1_reg} + {1'b0, s4_sq1_reg, 1'b0};
    assign s5_sq1x5 = {3'b0, s4_sq1_reg} + {1'b0, s4_sq1_reg, 2'b0};
    assign s5_sq2x7 = {s4_sq2_reg, 3'b0} - {3'b0, s4_sq2_reg};

    assign s5_offi_next  = s4_low_reg
                         ? ({3'b0, s5_sq1x3[37:1]} + (s4_vlow_reg ? {1'b0, s5_sq2x7} : 40'd0))
                         : {8'b0, s4_sq1_reg[35:4]};
    assign s5_sensi_next = s4_low_reg
                         ? ({4'b0, s5_sq1x5[38:3]}
                            + (s4_vlow_reg ? {2'b0, s4_sq2_reg, 2'b0} : 40'd0))
                         : 40'd0;

    // ------------------------------------------------------------------
    // Stage 6: OFF2, SENS2
    // ------------------------------------------------------------------
    logic signed [41:0]       s6_off2_next, s6_off2_reg;
    logic signed [41:0]       s6_sens2_next, s6_sens2_reg;
    logic signed [TEMP_W-1:0] s6_tcomp_reg;
    logic [RAW_W-1:0]         s6_d1_reg;

    assign s6_off2_next  = 42'(s5_off_reg) - $signed({2'b0, s5_offi_reg});
    assign s6_sens2_next = 42'(s5_sens_reg) - $signed({2'b0, s5_sensi_reg});

    // ------------------------------------------------------------------
    // Stage 7: D1 * SENS2 as two partial products (low half unsigned)
    // ------------------------------------------------------------------
    logic [44:0]              s7_pp_lo_next, s7_pp_lo_reg;
    logic signed [45:0]       s7_pp_hi_next, s7_pp_hi_reg;
    logic signed [41:0]       s7_off2_reg;
    logic signed [TEMP_W-1:0] s7_tcomp_reg;

    assign s7_pp_lo_next = s6_d1_reg * s6_sens2_reg[20:0];
    assign s7_pp_hi_next = $signed({1'b0, s6_d1_reg}) * $signed(s6_sens2_reg[41:21]);

    // ------------------------------------------------------------------
    // Stage 8: recombine partial products
    // ------------------------------------------------------------------
    logic signed [65:0]       s8_prod_next, s8_prod_reg;
    logic signed [41:0]       s8_off2_reg;
    logic signed [TEMP_W-1:0] s8_tcomp_reg;

    assign s8_prod_next = (66'(s7_pp_hi_reg) <<< 21) + $signed({21'b0, s7_pp_lo_reg});

    // ------------------------------------------------------------------
    // Stages 9..11: (D1*SENS2 / 2^21 - OFF2) / 2^13
    // ------------------------------------------------------------------
    logic signed [44:0]       s9_q21_next, s9_q21_reg;
    logic signed [41:0]       s9_off2_reg;
    logic signed [TEMP_W-1:0] s9_tcomp_reg;

    logic signed [45:0]       s10_diff_next, s10_diff_reg;
    logic signed [TEMP_W-1:0] s10_tcomp_reg;

    logic signed [32:0]       s11_pfull_next, s11_pfull_reg;
    logic signed [TEMP_W-1:0] s11_tcomp_reg;

    assign s9_q21_next    = 45'(sdiv_pow2(72'(s8_prod_reg), 21));
    assign s10_diff_next  = 46'(s9_q21_reg) - 46'(s9_off2_reg);
    assign s11_pfull_next = 33'(sdiv_pow2(72'(s10_diff_reg), 13));

    // ------------------------------------------------------------------
    // Stage 12: saturate to 32 bits
    // ------------------------------------------------------------------
    logic signed [PTENTH_W-1:0] s12_p_next, s12_p_reg;
    logic signed [TEMP_W-1:0]   s12_tcomp_reg;

    always_comb
    begin
        if (s11_pfull_reg > P_MAX)
            s12_p_next = PTENTH_W'(P_MAX);
        else if (s11_pfull_reg < P_MIN)
            s12_p_next = PTENTH_W'(P_MIN);
        else
            s12_p_next = s11_pfull_reg[PTENTH_W-1:0];
    end

    // ------------------------------------------------------------------
    // Stages 13..15: divide by ten on the magnitude, restore sign
    // ------------------------------------------------------------------
    logic [31:0]                s13_abs_next, s13_abs_reg;
    logic                       s13_neg_reg;
    logic signed [PTENTH_W-1:0] s13_p_reg;
    logic signed [TEMP_W-1:0]   s13_tcomp_reg;

    logic [63:0]                s14_m_next, s14_m_reg;
    logic                       s14_neg_reg;
    logic signed [PTENTH_W-1:0] s14_p_reg;
    logic signed [TEMP_W-1:0]   s14_tcomp_reg;

    logic [PMBAR_W-1:0]         s15_q;
    logic signed [PMBAR_W-1:0]  s15_mbar_next, s15_mbar_reg;
    logic signed [PTENTH_W-1:0] s15_p_reg;
    logic signed [TEMP_W-1:0]   s15_tcomp_reg;

    assign s13_abs_next  = s12_p_reg[PTENTH_W-1] ? (~s12_p_reg + 32'd1) : s12_p_reg;
    assign s14_m_next    = s13_abs_reg * DIV10_MUL;
    assign s15_q         = s14_m_reg[63:35];
    assign s15_mbar_next = s14_neg_reg ? -s15_q : s15_q;

    // ------------------------------------------------------------------
    // Datapath registers: no reset, qualified by valid_reg
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        s1_dt_reg     <= s1_dt_next;
        s1_d1_reg     <= raw_pressure;

        s2_tc_reg     <= s2_tc_next;
        s2_oc_reg     <= s2_oc_next;
        s2_sc_reg     <= s2_sc_next;
        s2_dtsq_reg   <= s2_dtsq_next;
        s2_d1_reg     <= s1_d1_reg;

        s3_dtemp_reg  <= s3_dtemp_next;
        s3_temp_reg   <= s3_temp_next;
        s3_off_reg    <= s3_off_next;
        s3_sens_reg   <= s3_sens_next;
        s3_low_reg    <= s3_low_next;
        s3_vlow_reg   <= s3_vlow_next;
        s3_ti_reg     <= s3_ti_next;
        s3_d1_reg     <= s2_d1_reg;

        s4_tcomp_reg  <= s4_tcomp_next;
        s4_sq1_reg    <= s4_sq1_next;
        s4_sq2_reg    <= s4_sq2_next;
        s4_off_reg    <= s3_off_reg;
        s4_sens_reg   <= s3_sens_reg;
        s4_low_reg    <= s3_low_reg;
        s4_vlow_reg   <= s3_vlow_reg;
        s4_d1_reg     <= s3_d1_reg;

        s5_offi_reg   <= s5_offi_next;
        s5_sensi_reg  <= s5_sensi_next;
        s5_off_reg    <= s4_off_reg;
        s5_sens_reg   <= s4_sens_reg;
        s5_tcomp_reg  <= s4_tcomp_reg;
        s5_d1_reg     <= s4_d1_reg;

        s6_off2_reg   <= s6_off2_next;
        s6_sens2_reg  <= s6_sens2_next;
        s6_tcomp_reg  <= s5_tcomp_reg;
        s6_d1_reg     <= s5_d1_reg;

        s7_pp_lo_reg  <= s7_pp_lo_next;
        s7_pp_hi_reg  <= s7_pp_hi_next;
        s7_off2_reg   <= s6_off2_reg;
        s7_tcomp_reg  <= s6_tcomp_reg;

        s8_prod_reg   <= s8_prod_next;
        s8_off2_reg   <= s7_off2_reg;
        s8_tcomp_reg  <= s7_tcomp_reg;

        s9_q21_reg    <= s9_q21_next;
        s9_off2_reg   <= s8_off2_reg;
        s9_tcomp_reg  <= s8_tcomp_reg;

        s10_diff_reg  <= s10_diff_next;
        s10_tcomp_reg <= s9_tcomp_reg;

        s11_pfull_reg <= s11_pfull_next;
        s11_tcomp_reg <= s10_tcomp_reg;

        s12_p_reg     <= s12_p_next;
        s12_tcomp_reg <= s11_tcomp_reg;

        s13_abs_reg   <= s13_abs_next;
        s13_neg_reg   <= s12_p_reg[PTENTH_W-1];
        s13_p_reg     <= s12_p_reg;
        s13_tcomp_reg <= s12_tcomp_reg;

        s14_m_reg     <= s14_m_next;
        s14_neg_reg   <= s13_neg_reg;
        s14_p_reg     <= s13_p_reg;
        s14_tcomp_reg <= s13_tcomp_reg;

        s15_mbar_reg  <= s15_mbar_next;
        s15_p_reg     <= s14_p_reg;
        s15_tcomp_reg <= s14_tcomp_reg;
    end

    assign temperature_centideg = s15_tcomp_reg;
    assign pressure_tenth_mbar  = s15_p_reg;
    assign pressure_mbar        = s15_mbar_reg;

endmodule

[rtl/ptc_checker.sv]
module ptc_checker
    import ptc_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       cfg_ready,
    input logic                       result_valid,
    input logic signed [PTENTH_W-1:0] pressure_tenth_mbar,
    input logic signed [PMBAR_W-1:0]  pressure_mbar
);

    // pipeline never back-pressures either port
    a_never_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && cfg_ready)
        else $error("busy or cfg_ready stall seen");

    // every transaction yields one result after the fixed latency
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY result_valid)
        else $error("result missing after accepted reading");

    // no result without a matching transaction
    a_latency_bwd: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy, LATENCY))
        else $error("result without accepted reading");

    // mbar value is the tenths value / 10 truncated toward zero, so a negative mbar implies negative tenths
    a_mbar_sign: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (!pressure_mbar[PMBAR_W-1] || pressure_tenth_mbar[PTENTH_W-1]))
        else $error("mbar sign disagrees with tenths value");

endmodule

bind pressure_temperature_compensation ptc_checker u_ptc_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .cfg_ready           (cfg_ready),
    .result_valid        (result_valid),
    .pressure_tenth_mbar (pressure_tenth_mbar),
    .pressure_mbar       (pressure_mbar)
);
